### hw/rtl/occ_pkg.sv
// Shared constants and types for the one's-complement checksum block.
// No dependencies; every other file refers to this package by scoped names.
package occ_pkg;

  localparam int unsigned DataBytes = 8;
  localparam int unsigned DataWidth = 8 * DataBytes;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned SumWidth = 16;
  localparam int unsigned LaneCount = DataBytes / 2;
  localparam int unsigned BytesPerItemDefault = 8;
  localparam logic [SumWidth-1:0] SumMask = 16'hFFFF;

  typedef logic [SumWidth-1:0] sum_t;
  typedef logic [CountWidth-1:0] count_t;

  // One input word as held in the input register.
  typedef struct packed {
    logic [DataWidth-1:0] data;
    count_t               byte_count;
    logic                 first;
    logic                 last;
    sum_t                 seed;
  } word_t;

endpackage

### hw/rtl/occ_channels.sv
// Handshake channels of the checksum block: the input word stream and the
// result stream. Depends on occ_pkg for field widths.
interface occ_word_if;
  logic                         valid;
  logic                         ready;
  logic [occ_pkg::DataWidth-1:0] data;
  occ_pkg::count_t              byte_count;
  logic                         first;
  logic                         last;
  occ_pkg::sum_t                seed;

  modport source (output valid, data, byte_count, first, last, seed, input ready);
  modport sink (input valid, data, byte_count, first, last, seed, output ready);
endinterface

interface occ_result_if;
  logic          valid;
  logic          ready;
  occ_pkg::sum_t checksum;

  modport source (output valid, checksum, input ready);
  modport sink (input valid, checksum, output ready);
endinterface

### hw/rtl/ones_complement_checksum.sv
// Top level of the streaming 16-bit one's-complement checksum.
// Depends on occ_pkg, occ_channels (occ_word_if, occ_result_if) and occ_word_sum.
//
//   Channel  Direction  Fields                                     Per word
//   stream   in         data, byte_count, first, last, seed        one input word
//   result   out        checksum                                   one per last word
//
// Each word is taken into an input register, summed by one stage of short
// logic and folded into the running sum register, so a word can be accepted
// in every cycle unless a last word is held behind an untaken result.
// A checksum is loaded into the output register as its last word leaves the
// input register. The output register lets the block keep accepting words
// while a result waits; only a second last word stalls behind an untaken result.
// Synchronous reset clears the valid flags and sets the running sum to zero.
module ones_complement_checksum #(
  parameter int unsigned BYTES_PER_ITEM = occ_pkg::BytesPerItemDefault
) (
  input logic         clk,
  input logic         rst,
  occ_word_if.sink    stream,
  occ_result_if.source result
);

  // Input register.
  logic           word_valid;
  occ_pkg::word_t word;

  // Running sum and output register.
  occ_pkg::sum_t running_sum;
  occ_pkg::sum_t running_sum_next;
  logic          out_valid;
  occ_pkg::sum_t checksum;

  occ_pkg::sum_t start;
  logic          advance;

  // The registered word moves on unless it would produce a result while the
  // output register still holds one that has not been taken.
  assign advance = word_valid && (!word.last || !out_valid || result.ready);
  assign stream.ready = !word_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (stream.ready) begin
      word_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      word.data       <= stream.data;
      word.byte_count <= stream.byte_count;
      word.first      <= stream.first;
      word.last       <= stream.last;
      word.seed       <= stream.seed;
    end
  end

  // The first word of a buffer restarts the sum at its seed.
  assign start = word.first ? word.seed : running_sum;

  occ_word_sum #(
    .BYTES_PER_ITEM(BYTES_PER_ITEM)
  ) u_word_sum (
    .data      (word.data),
    .byte_count(word.byte_count),
    .start     (start),
    .sum       (running_sum_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (advance) begin
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && word.last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && word.last) begin
      checksum <= running_sum_next;
    end
  end

  assign result.valid    = out_valid;
  assign result.checksum = checksum;

endmodule

### hw/rtl/occ_word_sum.sv
// Combinational adder for one word: masks bytes past the count, pairs them
// little-endian and adds them to a 16-bit start value with end-around carry.
// Depends on occ_pkg.
module occ_word_sum #(
  parameter int unsigned BYTES_PER_ITEM = occ_pkg::BytesPerItemDefault
) (
  input  logic [occ_pkg::DataWidth-1:0] data,
  input  occ_pkg::count_t               byte_count,
  input  occ_pkg::sum_t                 start,
  output occ_pkg::sum_t                 sum
);

  localparam int unsigned Limit =
    (BYTES_PER_ITEM < occ_pkg::DataBytes) ? BYTES_PER_ITEM : occ_pkg::DataBytes;
  localparam occ_pkg::count_t LimitCount = occ_pkg::CountWidth'(Limit);
  localparam int unsigned WideWidth = occ_pkg::SumWidth + $clog2(occ_pkg::LaneCount + 1);

  occ_pkg::count_t              count;
  logic [occ_pkg::DataWidth-1:0] masked;
  logic [WideWidth-1:0]         total;
  logic [occ_pkg::SumWidth:0]   fold1;
  logic [occ_pkg::SumWidth:0]   fold2;

  // Counts beyond what one word can carry saturate.
  assign count = (byte_count > LimitCount) ? LimitCount : byte_count;

  always_comb begin
    for (int k = 0; k < int'(occ_pkg::DataBytes); k++) begin
      masked[8*k +: 8] = (occ_pkg::CountWidth'(k) < count) ? data[8*k +: 8] : 8'h00;
    end
  end

  // A lone trailing byte lands in the low half because its partner is masked.
  always_comb begin
    total = WideWidth'(start);
    for (int i = 0; i < int'(occ_pkg::LaneCount); i++) begin
      total = total + WideWidth'(masked[16*i +: 16]);
    end
  end

  assign fold1 = (occ_pkg::SumWidth+1)'(total[occ_pkg::SumWidth-1:0])
               + (occ_pkg::SumWidth+1)'(total[WideWidth-1:occ_pkg::SumWidth]);
  assign fold2 = (occ_pkg::SumWidth+1)'(fold1[occ_pkg::SumWidth-1:0])
               + (occ_pkg::SumWidth+1)'(fold1[occ_pkg::SumWidth]);
  assign sum = fold2[occ_pkg::SumWidth-1:0] & occ_pkg::SumMask;

endmodule

### sim/tb.sv
// Self-checking testbench for the streaming one's-complement checksum block.
// Depends on occ_pkg and occ_channels from the RTL, and on ones_complement_checksum.
// Drives words with random gaps, stalls results at random and checks each checksum.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WordBytes = occ_pkg::DataBytes;
  localparam int unsigned MaxBytes = (occ_pkg::BytesPerItemDefault < WordBytes) ?
                                     occ_pkg::BytesPerItemDefault : WordBytes;

  logic clk;
  logic rst;

  occ_word_if   stream_ch ();
  occ_result_if result_ch ();

  ones_complement_checksum i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .result (result_ch)
  );

  // Predicted state of the block: the running one's-complement sum as it
  // stands after every word accepted so far.
  occ_pkg::sum_t buffer_sum;

  // Checksums predicted for last words, oldest first.
  occ_pkg::sum_t pending_checksums[$];

  int mismatch_count;
  int words_accepted;

  // When clear, neither the word source nor the result sink ever idles.
  bit idling;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on the whole run, far above the slowest legal run.
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int draw_idle();
    return idling ? int'($urandom_range(0, 16)) : 0;
  endfunction

  // Adds the valid bytes of one word to the predicted sum. Bytes pair
  // little-endian, so byte 2i is the low half of each 16-bit addend; a lone
  // trailing byte adds as a low half. Counts above what the word carries are
  // clipped, and a zero count adds nothing but a first word still loads its seed.
  function automatic void add_word_to_sum(input logic [occ_pkg::DataWidth-1:0] data,
                                          input occ_pkg::count_t cnt, input logic first,
                                          input occ_pkg::sum_t seed);
    logic [31:0] acc;
    int n;
    int k;
    n = (cnt > MaxBytes) ? MaxBytes : int'(cnt);
    acc = first ? 32'(seed) : 32'(buffer_sum);
    for (k = 0; k + 1 < n; k += 2) begin
      acc += 32'(data[8*k +: 16]);
    end
    if (k < n) begin
      acc += 32'(data[8*k +: 8]);
    end
    // End-around carry, folded twice as the carry of the first fold can
    // itself carry out of bit 15.
    acc = (acc & 32'h0000_FFFF) + (acc >> 16);
    acc = (acc & 32'h0000_FFFF) + (acc >> 16);
    buffer_sum = acc[15:0];
  endfunction

  // Offers one word after a random gap and holds it until the block takes
  // it. A word that follows with no gap keeps valid high, so valid is
  // assigned only once in that time step.
  task automatic send_word(input logic [occ_pkg::DataWidth-1:0] data,
                           input occ_pkg::count_t cnt, input logic first,
                           input logic last, input occ_pkg::sum_t seed);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      stream_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_ch.valid      <= 1'b1;
    stream_ch.data       <= data;
    stream_ch.byte_count <= cnt;
    stream_ch.first      <= first;
    stream_ch.last       <= last;
    stream_ch.seed       <= seed;
    // Values read right after the edge are those the block saw at the edge.
    do @(posedge clk); while (!stream_ch.ready);
    add_word_to_sum(data, cnt, first, seed);
    if (last) begin
      pending_checksums.push_back(buffer_sum);
    end
    words_accepted++;
  endtask

  function automatic logic [63:0] random_data();
    return {$urandom, $urandom};
  endfunction

  // Result sink: stalls a random number of cycles before each checksum and
  // compares every accepted checksum with the oldest prediction. Valid is
  // still unknown at the first edge, so only a clean high counts.
  initial begin
    int stall;
    occ_pkg::sum_t expected;
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      if (pending_checksums.size() == 0) begin
        $display("%0t: checksum expected none, got %h", $time, result_ch.checksum);
        mismatch_count++;
      end else begin
        expected = pending_checksums.pop_front();
        if (result_ch.checksum !== expected) begin
          $display("%0t: checksum expected %h, got %h", $time, expected,
                   result_ch.checksum);
          mismatch_count++;
        end
      end
    end
  end

  // A word without first straight after reset adds to a sum of zero.
  task automatic test_open_after_reset();
    send_word(random_data(), 4'd8, 1'b0, 1'b1, 16'h1234);
  endtask

  // Extremes of data and seed: all ones forces end-around carries on every
  // addend, all zeros gives a zero sum.
  task automatic test_field_extremes();
    send_word({occ_pkg::DataWidth{1'b1}}, 4'd8, 1'b1, 1'b1, 16'hFFFF);
    send_word('0, 4'd8, 1'b1, 1'b1, 16'h0000);
  endtask

  // Every byte count that the field can hold, as one-word buffers: zero
  // count, odd counts with a lone low byte, and counts past eight that clip.
  task automatic test_byte_counts();
    for (int c = 0; c < 16; c++) begin
      send_word(random_data(), occ_pkg::count_t'(c), 1'b1, 1'b1, 16'($urandom));
    end
  endtask

  // Words of a buffer that are short or odd before the last one restart
  // pairing at byte zero; a word without first then continues the sum of the
  // previous buffer; two last words back to back queue behind each other.
  task automatic test_multiword_buffers();
    send_word(random_data(), 4'd8, 1'b1, 1'b0, 16'($urandom));
    send_word(random_data(), 4'd3, 1'b0, 1'b0, 16'($urandom));
    send_word(random_data(), 4'd5, 1'b0, 1'b1, 16'($urandom));
    send_word(random_data(), 4'd7, 1'b0, 1'b1, 16'($urandom));
    send_word(random_data(), 4'd8, 1'b1, 1'b1, 16'($urandom));
    send_word(random_data(), 4'd1, 1'b1, 1'b1, 16'($urandom));
  endtask

  // Mostly well-formed buffers of random length and content, mixed with
  // single words whose every field is random.
  task automatic test_random_traffic(input int word_total);
    int target;
    int n;
    logic [63:0] data;
    occ_pkg::sum_t seed;
    target = words_accepted + word_total;
    while (words_accepted < target) begin
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          data = ($urandom_range(0, 7) == 0) ? '1 : random_data();
          case ($urandom_range(0, 7))
            0: begin
              seed = 16'hFFFF;
            end
            1: begin
              seed = 16'h0000;
            end
            default: begin
              seed = 16'($urandom);
            end
          endcase
          send_word(data, (i == n - 1) ? occ_pkg::count_t'($urandom_range(1, 8)) : 4'd8,
                    i == 0, i == n - 1, seed);
        end
      end else begin
        send_word(random_data(), occ_pkg::count_t'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom));
      end
    end
  endtask

  initial begin
    int guard;
    rst                  <= 1'b1;
    stream_ch.valid      <= 1'b0;
    stream_ch.data       <= '0;
    stream_ch.byte_count <= '0;
    stream_ch.first      <= 1'b0;
    stream_ch.last       <= 1'b0;
    stream_ch.seed       <= '0;
    buffer_sum = '0;
    mismatch_count = 0;
    words_accepted = 0;
    idling = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed words go in back to back.
    test_open_after_reset();
    test_field_extremes();
    test_byte_counts();
    test_multiword_buffers();

    // Random traffic, first with gaps and stalls on both sides, then a
    // stretch at full rate.
    idling = 1'b1;
    test_random_traffic(560);
    idling = 1'b0;
    test_random_traffic(90);

    stream_ch.valid <= 1'b0;

    // Drain: wait for every predicted checksum, then keep the clock running so
    // that a spurious extra result would still be seen.
    guard = 0;
    while (pending_checksums.size() != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_checksums.size() != 0) begin
      $display("%0t: outstanding checksums expected 0, got %0d", $time,
               pending_checksums.size());
      mismatch_count++;
    end
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/occ_pkg.sv
hw/rtl/occ_channels.sv
hw/rtl/occ_word_sum.sv
hw/rtl/ones_complement_checksum.sv
sim/tb.sv
